/* src/qcqc_pkg.sv */
// shared types and constants for the quad channel quadrature counter
// no dependencies
`default_nettype none

package qcqc_pkg;

  localparam int PINS_W       = 8;
  localparam int PHASE_W      = 2;
  localparam int CHAN_W       = 2;
  localparam int OUT_W        = 32;
  localparam int MAX_CHANNELS = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_INIT   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [PHASE_W-1:0] PHASE_JUMP = 2'b11;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // indexed by {previous phase, new phase}
  localparam step_t STEP_LUT [0:15] = '{
    STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE,
    STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
    STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
    STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE
  };

  typedef struct packed {
    logic                    report;
    logic [MAX_CHANNELS-1:0] up;
    logic [MAX_CHANNELS-1:0] down;
    logic [MAX_CHANNELS-1:0] jump;
  } cmd_t;

endpackage

`default_nettype wire

/* src/qcqc_ifs.sv */
// valid/ready channel interfaces for pin samples and channel reports
// depends on qcqc_pkg
`default_nettype none

interface qcqc_in_if;
  import qcqc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [PINS_W-1:0]  pins;

  modport source (output valid, op, pins, input ready);
  modport sink   (input valid, op, pins, output ready);
endinterface

interface qcqc_out_if;
  import qcqc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHAN_W-1:0]       channel;
  logic signed [OUT_W-1:0] period_count;
  logic signed [OUT_W-1:0] total_count;
  logic [OUT_W-1:0]        invalid_count;
  logic                    last;

  modport source (output valid, channel, period_count, total_count, invalid_count, last,
                  input ready);
  modport sink   (input valid, channel, period_count, total_count, invalid_count, last,
                  output ready);
endinterface

`default_nettype wire

/* src/qcqc_front.sv */
// front end: accepts pin samples, tracks phases, turns samples into step commands
// depends on qcqc_pkg and qcqc_ifs
`default_nettype none

module qcqc_front #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  qcqc_in_if.sink         samples,
  output logic            push_valid,
  input  wire logic       push_ready,
  output qcqc_pkg::cmd_t  push_cmd
);
  import qcqc_pkg::*;

  localparam int PAD_W = 2 * NUM_CHANNELS + PINS_W;

  logic [PHASE_W-1:0] phase [NUM_CHANNELS];
  logic [PHASE_W-1:0] cur   [NUM_CHANNELS];
  step_t              step  [NUM_CHANNELS];
  logic [PAD_W-1:0]   pins_ext;
  logic               accept;
  logic               load_phase;

  assign samples.ready = push_ready;
  assign accept        = samples.valid && push_ready;
  assign load_phase    = accept && (samples.op == OP_SAMPLE || samples.op == OP_INIT);
  assign push_valid    = samples.valid && (samples.op == OP_SAMPLE || samples.op == OP_REPORT);

  always_comb begin
    pins_ext        = PAD_W'(samples.pins);
    push_cmd        = '0;
    push_cmd.report = (samples.op == OP_REPORT);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      cur[c]  = pins_ext[2*c +: PHASE_W];
      step[c] = STEP_LUT[{phase[c], cur[c]}];
      if (samples.op == OP_SAMPLE) begin
        push_cmd.up[c]   = (step[c] == STEP_UP);
        push_cmd.down[c] = (step[c] == STEP_DOWN);
        push_cmd.jump[c] = ((phase[c] ^ cur[c]) == PHASE_JUMP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) phase[c] <= '0;
    end else if (load_phase) begin
      for (int c = 0; c < NUM_CHANNELS; c++) phase[c] <= cur[c];
    end
  end

endmodule

`default_nettype wire

/* src/qcqc_fifo.sv */
// short command queue between front and back ends
// depends on qcqc_pkg
`default_nettype none

module qcqc_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire qcqc_pkg::cmd_t  wr_cmd,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output qcqc_pkg::cmd_t       rd_cmd
);
  import qcqc_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_cmd   = entry[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/qcqc_back.sv */
// back end: per-channel counters, report sequencing and output register
// depends on qcqc_pkg and qcqc_ifs
`default_nettype none

module qcqc_back #(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_valid,
  output logic                 rd_ready,
  input  wire qcqc_pkg::cmd_t  rd_cmd,
  qcqc_out_if.source           results
);
  import qcqc_pkg::*;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_IDX_W-1:0]    LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] total   [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] period  [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] invalid [NUM_CHANNELS];
  logic [CH_IDX_W-1:0]    rpt_idx;
  logic                   out_valid;
  logic                   out_free;
  logic                   emit;
  logic                   apply;
  logic                   last_ch;

  assign out_free      = !out_valid || results.ready;
  assign last_ch       = (rpt_idx == LAST_CH);
  assign emit          = rd_valid && rd_cmd.report && out_free;
  assign apply         = rd_valid && !rd_cmd.report;
  assign rd_ready      = apply || (emit && last_ch);
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        total[c]   <= '0;
        period[c]  <= '0;
        invalid[c] <= '0;
      end
      rpt_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (rd_cmd.up[c]) begin
            total[c]  <= total[c] + CNT_ONE;
            period[c] <= period[c] + CNT_ONE;
          end else if (rd_cmd.down[c]) begin
            total[c]  <= total[c] - CNT_ONE;
            period[c] <= period[c] - CNT_ONE;
          end
          if (rd_cmd.jump[c]) begin
            invalid[c] <= invalid[c] + CNT_ONE;
          end
        end
      end
      if (emit) begin
        period[rpt_idx] <= '0;
        rpt_idx         <= last_ch ? '0 : rpt_idx + CH_IDX_W'(1);
        out_valid       <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.channel       <= CHAN_W'(rpt_idx);
      results.period_count  <= OUT_W'(period[rpt_idx]);
      results.total_count   <= OUT_W'(total[rpt_idx]);
      results.invalid_count <= OUT_W'(invalid[rpt_idx]);
      results.last          <= last_ch;
    end
  end

endmodule

`default_nettype wire

/* src/quad_channel_quadrature_counter_core.sv */
// quad channel x4 quadrature counter, top level
// a report is registered in the queue, then its first result in the output register
// throughput: one sample or init per cycle while the two-entry queue has room, even while
//   a report holds the counter stage for one result per channel, one per cycle if taken
// reset: synchronous rst clears phases, all counters, the queue and the output valid flag
// depends on qcqc_pkg, qcqc_ifs, qcqc_front, qcqc_fifo, qcqc_back
`default_nettype none

module quad_channel_quadrature_counter_core #(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  qcqc_in_if.sink     samples,
  qcqc_out_if.source  results
);
  import qcqc_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  qcqc_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  qcqc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_cmd   (pop_cmd)
  );

  qcqc_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_cmd   (pop_cmd),
    .results  (results)
  );

endmodule

`default_nettype wire
